### sv/gsfr_pkg.sv
// shared types and constants for the gas sensor frame receiver
package gsfr_pkg;

	localparam logic [7:0] START_BYTE       = 8'hFF;
	localparam logic [7:0] GAS_TYPE_RESET   = 8'h17;
	localparam logic [7:0] UNIT_RESET       = 8'h04;

	// frame position: 0 hunts, 1..8 is the index of the next collected byte plus one
	localparam logic [3:0] POS_HUNT         = 4'd0;
	localparam logic [3:0] POS_FIRST        = 4'd1;
	localparam logic [3:0] POS_LAST         = 4'd8;

	// collected byte indexes
	localparam logic [3:0] IDX_GAS_TYPE     = 4'd0;
	localparam logic [3:0] IDX_UNIT         = 4'd1;
	localparam logic [3:0] IDX_READ_HIGH    = 4'd3;
	localparam logic [3:0] IDX_READ_LOW     = 4'd4;
	localparam logic [3:0] SUMMED_BYTES     = 4'd7;
	localparam logic [3:0] IDX_CHECK        = 4'd7;

	// configuration register indexes
	localparam logic REG_GAS_TYPE = 1'b0;
	localparam logic REG_UNIT     = 1'b1;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef struct packed {
		logic        frame_status;
		logic [15:0] concentration;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} result_beat_t;

endpackage

### sv/gsfr_parser.sv
// frame hunting, byte collection and checksum check for one received byte a cycle while accept is high
module gsfr_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            expected_gas_type,
	input  logic [7:0]            expected_unit,
	output gsfr_pkg::result_beat_t result
);
	import gsfr_pkg::*;

	logic [3:0] pos_q;
	logic [7:0] sum_q;
	logic       type_ok_q;
	logic       unit_ok_q;
	logic [7:0] read_high_q;
	logic [7:0] read_low_q;

	logic       hunting;
	logic [3:0] idx;
	logic [7:0] check;
	logic       frame_ok;

	assign hunting  = (pos_q == POS_HUNT) || (pos_q > POS_LAST);
	assign idx      = pos_q - POS_FIRST;
	assign check    = 8'd0 - sum_q;
	assign frame_ok = type_ok_q && unit_ok_q && (rx_byte == check);

	always_comb begin
		result.valid              = accept && !hunting && (idx == IDX_CHECK);
		result.data.frame_status  = frame_ok ? STATUS_OK : STATUS_REJECT;
		result.data.concentration = frame_ok ? {read_high_q, read_low_q} : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_HUNT;
			sum_q       <= 8'd0;
			type_ok_q   <= 1'b0;
			unit_ok_q   <= 1'b0;
			read_high_q <= 8'd0;
			read_low_q  <= 8'd0;
		end else if (accept) begin
			if (hunting) begin
				if (rx_byte == START_BYTE) begin
					pos_q       <= POS_FIRST;
					sum_q       <= 8'd0;
					type_ok_q   <= 1'b0;
					unit_ok_q   <= 1'b0;
					read_high_q <= 8'd0;
					read_low_q  <= 8'd0;
				end else begin
					pos_q <= POS_HUNT;
				end
			end else begin
				if (idx < SUMMED_BYTES)
					sum_q <= sum_q + rx_byte;
				if (idx == IDX_GAS_TYPE)
					type_ok_q <= (rx_byte == expected_gas_type);
				if (idx == IDX_UNIT)
					unit_ok_q <= (rx_byte == expected_unit);
				if (idx == IDX_READ_HIGH)
					read_high_q <= rx_byte;
				if (idx == IDX_READ_LOW)
					read_low_q <= rx_byte;
				if (idx == IDX_CHECK)
					pos_q <= POS_HUNT;
				else
					pos_q <= pos_q + 4'd1;
			end
		end
	end

endmodule

### sv/gsfr_out_buf.sv
// two-entry result buffer: a pair of entries written and read through toggling pointers
module gsfr_out_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gsfr_pkg::result_beat_t push,
	output logic                   full,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   frame_status,
	output logic [15:0]            concentration
);
	import gsfr_pkg::*;

	result_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign full          = (cnt_q == 2'd2);
	assign out_valid     = (cnt_q != 2'd0);
	assign pop           = out_valid && !out_stall;
	assign frame_status  = mem_q[rd_ptr_q].frame_status;
	assign concentration = mem_q[rd_ptr_q].concentration;

	always_ff @(posedge clk) begin
		if (push.valid)
			mem_q[wr_ptr_q] <= push.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push.valid)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push.valid, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### sv/gas_sensor_frame_receiver.sv
// top level of the gas sensor frame receiver
//
// usage
// - rx channel: one received serial byte per beat on rx_byte, taken at a rising
//   edge with rx_valid high and rx_stall low
// - out channel: one beat per nine-byte frame (0xFF start byte plus eight bytes)
//   carrying frame_status (0 good, 1 rejected) and concentration (bytes three and
//   four, big-endian, zero when rejected)
// - cfg port: cfg_we with cfg_index 0 writes expected_gas_type, index 1 writes
//   expected_unit, data on cfg_wdata; write only while no frame is in progress
// - throughput: one byte per cycle while rx_stall is low
// - latency: out_valid is high the cycle after the checksum byte is taken
// - receiver stall: results wait in a two-entry buffer; rx_stall rises only when
//   both entries hold results, so bytes keep flowing while one result waits
// - reset: hunting for a start byte, buffer empty, registers back to 0x17 and 0x04
module gas_sensor_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic        frame_status,
	output logic [15:0] concentration,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata
);
	import gsfr_pkg::*;

	logic         rx_accept;
	logic [7:0]   gas_type_q;
	logic [7:0]   unit_q;
	logic         buf_full;
	result_beat_t result;

	// byte taken this edge
	assign rx_accept = rx_valid && !rx_stall;
	// stall only when the buffer cannot hold another result
	assign rx_stall  = buf_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gas_type_q <= GAS_TYPE_RESET;
			unit_q     <= UNIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAS_TYPE: gas_type_q <= cfg_wdata;
				REG_UNIT:     unit_q     <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	// frame tracking and check
	gsfr_parser u_parser (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (rx_accept),
		.rx_byte           (rx_byte),
		.expected_gas_type (gas_type_q),
		.expected_unit     (unit_q),
		.result            (result)
	);

	// two-entry result buffer
	gsfr_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (result),
		.full          (buf_full),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_status  (frame_status),
		.concentration (concentration)
	);

`ifndef SYNTH
	// a full buffer always shows a result
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> out_valid)
		else $error("rx_stall high with no result pending");

	// a finished frame shows a result the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |=> out_valid)
		else $error("result of a finished frame not presented");

	// rejected frames carry a zero reading
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_status == STATUS_REJECT) |-> concentration == 16'd0)
		else $error("rejected frame with nonzero concentration");

	// results only come from accepted bytes
	a_result_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> rx_accept)
		else $error("result produced without an accepted byte");
`endif

endmodule
